// ===== rtl/core/rbfe_pkg.sv =====
// Package for the Gaussian RBF network evaluator.
// Request and result payload types and the fixed-point constants.
// No dependencies.
package rbfe_pkg;

  // One input request: sample element or parameter word
  typedef struct packed {
    logic               mode;
    logic [6:0]         index;
    logic signed [31:0] value;
  } rbfe_req_t;

  // One result request: one network output
  typedef struct packed {
    logic        output_index;
    logic [16:0] output_value;
    logic        last;
  } rbfe_res_t;

  localparam logic       MODE_SAMPLE = 1'b0;
  localparam logic       MODE_LOAD   = 1'b1;

  // 1e-6 with 32 fraction bits, rounded
  localparam logic [12:0] DEN_FLOOR   = 13'd4295;
  // 32.0 in Q16.16
  localparam logic [21:0] SUM_CAP     = 22'h200000;
  // exp(-1) in Q0.32
  localparam logic [31:0] EXP_M1_Q32  = 32'd1580030169;
  // last Taylor term index
  localparam logic [3:0]  TAYLOR_LAST = 4'd13;
  // 1.0 in Q1.16
  localparam logic [16:0] PHI_ONE     = 17'd65536;

endpackage

// ===== rtl/core/rbfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Used for all parameter and activation stores. No dependencies.
module rbfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/gaussian_rbf_network_eval.sv =====
// Gaussian RBF network evaluator, top level: sequencer, shared datapath, stores.
// Depends on rbfe_pkg and rbfe_ram.
//
// Loads (mode 1) write a bias word at once; other words go through the S_LDEC
// state, spent on the flat index decode. A sample element that is not the
// last is written at once. The last element starts an evaluation that runs on one
// shared 33x32 multiplier, a one-bit-per-cycle ratio divider and an
// 8-bit-per-cycle Taylor divider. A (unit, element) pair skips the ratio divider
// when the term saturates, exp(-s) takes one exp(-1) factor per unit of the
// integer part of s, and each output is held until the result side takes it.
// The block takes no request while an evaluation runs.
module gaussian_rbf_network_eval import rbfe_pkg::*; #(
  parameter int NUM_INPUTS  = 4,
  parameter int NUM_UNITS   = 8,
  parameter int NUM_OUTPUTS = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  rbfe_req_t req,
  output logic      res_valid,
  input  logic      res_stall,
  output rbfe_res_t res
);

  localparam int UW     = 2 * NUM_INPUTS + NUM_OUTPUTS;
  localparam int CW_D   = NUM_UNITS * NUM_INPUTS;
  localparam int WG_D   = NUM_UNITS * NUM_OUTPUTS;
  localparam int CW_AW  = (CW_D > 1) ? $clog2(CW_D) : 1;
  localparam int WG_AW  = (WG_D > 1) ? $clog2(WG_D) : 1;
  localparam int XI_AW  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int ACT_AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int BI_AW  = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int ACC_W  = 50 + $clog2(NUM_UNITS + 1);
  // reciprocal of the per-unit word count, 16 fraction bits, rounded up;
  // exact unit number for any 7-bit word offset
  localparam int LD_RCP = ((1 << 16) + UW - 1) / UW;

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LDEC  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_DIFF  = 5'd3;
  localparam logic [4:0] S_MNUM  = 5'd4;
  localparam logic [4:0] S_MDEN  = 5'd5;
  localparam logic [4:0] S_DCHK  = 5'd6;
  localparam logic [4:0] S_DIV   = 5'd7;
  localparam logic [4:0] S_ADD   = 5'd8;
  localparam logic [4:0] S_EXP   = 5'd9;
  localparam logic [4:0] S_TMUL  = 5'd10;
  localparam logic [4:0] S_TDIV  = 5'd11;
  localparam logic [4:0] S_CLAMP = 5'd12;
  localparam logic [4:0] S_EMUL  = 5'd13;
  localparam logic [4:0] S_ROUND = 5'd14;
  localparam logic [4:0] S_OB    = 5'd15;
  localparam logic [4:0] S_OBW   = 5'd16;
  localparam logic [4:0] S_ORD   = 5'd17;
  localparam logic [4:0] S_OMAC  = 5'd18;
  localparam logic [4:0] S_OADD  = 5'd19;
  localparam logic [4:0] S_OFIN  = 5'd20;
  localparam logic [4:0] S_OWAIT = 5'd21;

  logic [4:0] state;

  // store ports
  logic              cen_we, wid_we, wgt_we, xin_we, bias_we, act_we;
  logic [CW_AW-1:0]  cw_waddr;
  logic [WG_AW-1:0]  wg_waddr;
  logic [31:0]       cen_rdata, wid_rdata, wgt_rdata, xin_rdata, bias_rdata;
  logic [16:0]       act_rdata;

  // counters and address registers
  logic [CW_AW-1:0]  e;
  logic [XI_AW-1:0]  i;
  logic [ACT_AW-1:0] u;
  logic [WG_AW-1:0]  wa;
  logic [BI_AW-1:0]  ko;

  // load decode
  logic [6:0]        ld_r;
  logic [31:0]       ld_val;
  logic [23:0]       ld_prod;
  logic [7:0]        ld_unit;
  logic [15:0]       ld_sub, cw_idx, wg_idx;
  logic [6:0]        ld_off;

  // ratio datapath
  logic [31:0]       dmag, bmag;
  logic [63:0]       num;
  logic [83:0]       dsh, rem;
  logic [21:0]       q;
  logic [4:0]        j;
  logic [21:0]       sum;

  // exp datapath
  logic [31:0]       fq, term, dq;
  logic [3:0]        drem, kk;
  logic [1:0]        dcnt;
  logic signed [34:0] eacc;
  logic [32:0]       ea;
  logic [4:0]        nleft;

  // output datapath
  logic              wneg;
  logic [64:0]       prod;
  logic signed [ACC_W-1:0] oacc;

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;

  // handshakes
  logic req_take, res_take;
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign res_take  = res_valid && !res_stall;

  // ---------------- stores ----------------
  rbfe_ram #(.WIDTH(32), .DEPTH(CW_D)) u_cen (
    .clk(clk), .we(cen_we), .waddr(cw_waddr), .wdata(ld_val),
    .raddr(e), .rdata(cen_rdata)
  );
  rbfe_ram #(.WIDTH(32), .DEPTH(CW_D)) u_wid (
    .clk(clk), .we(wid_we), .waddr(cw_waddr), .wdata(ld_val),
    .raddr(e), .rdata(wid_rdata)
  );
  rbfe_ram #(.WIDTH(32), .DEPTH(WG_D)) u_wgt (
    .clk(clk), .we(wgt_we), .waddr(wg_waddr), .wdata(ld_val),
    .raddr(wa), .rdata(wgt_rdata)
  );
  rbfe_ram #(.WIDTH(32), .DEPTH(NUM_INPUTS)) u_xin (
    .clk(clk), .we(xin_we), .waddr(req.index[XI_AW-1:0]), .wdata(req.value),
    .raddr(i), .rdata(xin_rdata)
  );
  rbfe_ram #(.WIDTH(32), .DEPTH(NUM_OUTPUTS)) u_bias (
    .clk(clk), .we(bias_we), .waddr(req.index[BI_AW-1:0]), .wdata(req.value),
    .raddr(ko), .rdata(bias_rdata)
  );
  logic [16:0] phi;
  rbfe_ram #(.WIDTH(17), .DEPTH(NUM_UNITS)) u_act (
    .clk(clk), .we(act_we), .waddr(u), .wdata(phi),
    .raddr(u), .rdata(act_rdata)
  );

  // ---------------- request decode ----------------
  // unit number by reciprocal multiplication, then the offset inside the unit
  logic ld_unit_ok, ld_in_cw;
  assign ld_prod    = 24'(ld_r) * 24'(LD_RCP);
  assign ld_unit    = ld_prod[23:16];
  assign ld_sub     = 16'(ld_unit) * 16'(UW);
  assign ld_off     = ld_r - ld_sub[6:0];
  assign ld_unit_ok = (ld_unit < 8'(NUM_UNITS));
  assign ld_in_cw   = ({1'b0, ld_off} < 8'(2 * NUM_INPUTS));
  assign cw_idx     = 16'(ld_unit) * 16'(NUM_INPUTS) + 16'(ld_off[6:1]);
  assign wg_idx     = 16'(ld_unit) * 16'(NUM_OUTPUTS) +
                      16'(ld_off - 7'(2 * NUM_INPUTS));
  assign cw_waddr   = cw_idx[CW_AW-1:0];
  assign wg_waddr   = wg_idx[WG_AW-1:0];

  logic ld_write;
  assign ld_write = (state == S_LDEC) && ld_unit_ok;
  assign cen_we   = ld_write && ld_in_cw && !ld_off[0];
  assign wid_we   = ld_write && ld_in_cw && ld_off[0];
  assign wgt_we   = ld_write && !ld_in_cw;
  assign bias_we  = req_take && (req.mode == MODE_LOAD) &&
                    ({1'b0, req.index} < 8'(NUM_OUTPUTS));
  assign xin_we   = req_take && (req.mode == MODE_SAMPLE) &&
                    ({1'b0, req.index} < 8'(NUM_INPUTS));
  assign act_we   = (state == S_ROUND);

  // ---------------- shared multiplier operands ----------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MNUM: begin mul_a = {1'b0, dmag}; mul_b = dmag; end
      S_MDEN: begin mul_a = {1'b0, bmag}; mul_b = bmag; end
      S_TMUL: begin mul_a = {1'b0, term}; mul_b = fq; end
      S_EMUL: begin mul_a = ea; mul_b = EXP_M1_Q32; end
      S_OMAC: begin
        mul_a = wgt_rdata[31] ? {1'b0, ~wgt_rdata + 32'd1} : {1'b0, wgt_rdata};
        mul_b = {15'd0, act_rdata};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // ---------------- element difference and width magnitude ----------------
  logic [32:0] diff;
  assign diff = {xin_rdata[31], xin_rdata} - {cen_rdata[31], cen_rdata};

  // squared width with the floor applied
  logic [63:0] den_raw;
  assign den_raw = (mul_p[63:0] < 64'(DEN_FLOOR)) ? 64'(DEN_FLOOR) : mul_p[63:0];

  // ratio divider step and saturation check
  logic        div_ge, ratio_sat;
  assign div_ge    = (rem >= dsh);
  assign ratio_sat = ({5'd0, num, 16'd0} >= {dsh, 1'b0});

  // running sum with saturation
  logic [22:0] sum_add;
  logic [21:0] sum_term;
  assign sum_term = q;
  assign sum_add  = {1'b0, sum} + {1'b0, sum_term};

  // Taylor divider: eight quotient bits per cycle by a 4-bit divisor
  logic [31:0] dq_next;
  logic [3:0]  drem_next;
  always_comb begin
    logic [31:0] dv;
    logic [4:0]  rr;
    dv = dq;
    rr = {1'b0, drem};
    for (int s = 0; s < 8; s++) begin
      rr = {rr[3:0], dv[31]};
      dv = {dv[30:0], 1'b0};
      if (rr >= {1'b0, kk}) begin
        rr    = rr - {1'b0, kk};
        dv[0] = 1'b1;
      end
    end
    dq_next   = dv;
    drem_next = rr[3:0];
  end

  // rounding to Q1.16
  logic [33:0] ea_rnd;
  assign ea_rnd = {1'b0, ea} + 34'd32768;
  assign phi    = (ea_rnd[33:16] > 18'(PHI_ONE)) ? PHI_ONE : ea_rnd[32:16];

  // output clamp
  logic [16:0] y;
  always_comb begin
    if (oacc <= 0) begin
      y = '0;
    end else if (oacc >= (ACC_W'(1) <<< 32)) begin
      y = PHI_ONE;
    end else begin
      y = oacc[32:16];
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            if (req.mode == MODE_LOAD) begin
              if ({1'b0, req.index} >= 8'(NUM_OUTPUTS)) begin
                ld_r   <= req.index - 7'(NUM_OUTPUTS);
                ld_val <= req.value;
                state  <= S_LDEC;
              end
            end else if ({1'b0, req.index} == 8'(NUM_INPUTS - 1)) begin
              e     <= '0;
              i     <= '0;
              u     <= '0;
              sum   <= '0;
              state <= S_RD;
            end
          end
        end

        // parameter word written this cycle from the decoded index
        S_LDEC: state <= S_IDLE;

        S_RD: state <= S_DIFF;

        S_DIFF: begin
          dmag  <= diff[32] ? 32'(~diff + 33'd1) : diff[31:0];
          bmag  <= wid_rdata[31] ? (~wid_rdata + 32'd1) : wid_rdata;
          state <= S_MNUM;
        end

        S_MNUM: begin
          num   <= mul_p[63:0];
          state <= S_MDEN;
        end

        S_MDEN: begin
          dsh   <= {den_raw[63:0], 20'd0};
          state <= S_DCHK;
        end

        S_DCHK: begin
          if (ratio_sat) begin
            q     <= SUM_CAP;
            state <= S_ADD;
          end else begin
            rem   <= {4'd0, num, 16'd0};
            q     <= '0;
            j     <= '0;
            state <= S_DIV;
          end
        end

        // restoring division, one quotient bit per cycle (21 bits)
        S_DIV: begin
          if (div_ge) begin
            rem <= rem - dsh;
          end
          q   <= {q[20:0], div_ge};
          dsh <= {1'b0, dsh[83:1]};
          j   <= j + 5'd1;
          if (j == 5'd20) begin
            state <= S_ADD;
          end
        end

        S_ADD: begin
          sum <= (sum_add > {1'b0, SUM_CAP}) ? SUM_CAP : sum_add[21:0];
          e   <= e + CW_AW'(1);
          if (i == XI_AW'(NUM_INPUTS - 1)) begin
            i     <= '0;
            state <= S_EXP;
          end else begin
            i     <= i + XI_AW'(1);
            state <= S_RD;
          end
        end

        // first Taylor term is the fraction itself
        S_EXP: begin
          if (sum >= SUM_CAP) begin
            ea    <= '0;
            state <= S_ROUND;
          end else begin
            fq    <= {sum[15:0], 16'd0};
            term  <= {sum[15:0], 16'd0};
            eacc  <= 35'sh100000000 - $signed({3'd0, sum[15:0], 16'd0});
            nleft <= sum[20:16];
            kk    <= 4'd2;
            state <= S_TMUL;
          end
        end

        S_TMUL: begin
          dq    <= mul_p[63:32];
          drem  <= '0;
          dcnt  <= '0;
          state <= S_TDIV;
        end

        S_TDIV: begin
          dq   <= dq_next;
          drem <= drem_next;
          dcnt <= dcnt + 2'd1;
          if (dcnt == 2'd3) begin
            term <= dq_next;
            if (kk[0]) begin
              eacc <= eacc - $signed({3'd0, dq_next});
            end else begin
              eacc <= eacc + $signed({3'd0, dq_next});
            end
            kk    <= kk + 4'd1;
            state <= (kk == TAYLOR_LAST) ? S_CLAMP : S_TMUL;
          end
        end

        S_CLAMP: begin
          if (eacc < 0) begin
            ea <= '0;
          end else if (eacc > 35'sh100000000) begin
            ea <= 33'h100000000;
          end else begin
            ea <= eacc[32:0];
          end
          state <= S_EMUL;
        end

        // one exp(-1) factor per cycle for the integer part
        S_EMUL: begin
          if (nleft == 5'd0) begin
            state <= S_ROUND;
          end else begin
            ea    <= mul_p[64:32];
            nleft <= nleft - 5'd1;
          end
        end

        S_ROUND: begin
          if (u == ACT_AW'(NUM_UNITS - 1)) begin
            u     <= '0;
            ko    <= '0;
            wa    <= '0;
            state <= S_OB;
          end else begin
            u     <= u + ACT_AW'(1);
            sum   <= '0;
            state <= S_RD;
          end
        end

        S_OB: state <= S_OBW;

        S_OBW: begin
          oacc  <= ACC_W'($signed(bias_rdata)) <<< 16;
          state <= S_OMAC;
        end

        S_ORD: state <= S_OMAC;

        S_OMAC: begin
          prod  <= mul_p;
          wneg  <= wgt_rdata[31];
          state <= S_OADD;
        end

        S_OADD: begin
          if (wneg) begin
            oacc <= oacc - $signed({1'b0, prod[48:0]});
          end else begin
            oacc <= oacc + $signed({1'b0, prod[48:0]});
          end
          if (u == ACT_AW'(NUM_UNITS - 1)) begin
            state <= S_OFIN;
          end else begin
            u     <= u + ACT_AW'(1);
            wa    <= wa + WG_AW'(NUM_OUTPUTS);
            state <= S_ORD;
          end
        end

        S_OFIN: begin
          res.output_index <= ko[0];
          res.output_value <= y;
          res.last         <= (ko == BI_AW'(NUM_OUTPUTS - 1));
          res_valid        <= 1'b1;
          state            <= S_OWAIT;
        end

        S_OWAIT: begin
          if (res_take) begin
            res_valid <= 1'b0;
            if (ko == BI_AW'(NUM_OUTPUTS - 1)) begin
              state <= S_IDLE;
            end else begin
              ko    <= ko + BI_AW'(1);
              u     <= '0;
              wa    <= WG_AW'(ko) + WG_AW'(1);
              state <= S_OB;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/gaussian_rbf_network_eval_tb.sv =====
// Testbench for gaussian_rbf_network_eval: loads parameters, streams sample vectors,
// and checks every network output against a bit-exact fixed-point predictor.
// Depends on rbfe_pkg and the evaluator RTL.
module gaussian_rbf_network_eval_tb;
  import rbfe_pkg::*;

  localparam int NIN   = 4;
  localparam int NUNIT = 8;
  localparam int NOUT  = 2;
  localparam int UNIT_WORDS = 2 * NIN + NOUT;
  localparam int NWORDS = NOUT + NUNIT * UNIT_WORDS;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  rbfe_req_t req = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  rbfe_res_t res;

  // predictor copy of the network parameters
  logic signed [31:0] p_input [NIN];
  logic signed [31:0] p_center [NUNIT*NIN];
  logic signed [31:0] p_width [NUNIT*NIN];
  logic signed [31:0] p_weight [NUNIT*NOUT];
  logic signed [31:0] p_bias [NOUT];

  rbfe_res_t expected_outputs[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  idle_enable = 1'b1;

  gaussian_rbf_network_eval u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // (x-c)^2 / b^2 as Q16.16, saturated at 32.0
  function automatic logic [63:0] ratio_q16(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, rem, frac;
    q = num / den;
    if (q >= 64'd32) return 64'd32 << 16;
    rem = num - q * den;
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= den) begin
        rem = rem - den;
        frac[0] = 1'b1;
      end
    end
    return (q << 16) | frac;
  endfunction

  // exp(-s) by Taylor series on the fraction, then repeated exp(-1)
  function automatic logic [16:0] gauss_act(logic [63:0] s);
    logic [63:0] n, fq, term, a;
    longint acc;
    if (s >= (64'd32 << 16)) return '0;
    n = s >> 16;
    fq = (s & 64'hFFFF) << 16;
    term = 64'd1 << 32;
    acc = longint'(64'd1 << 32);
    for (int k = 1; k <= 13; k++) begin
      term = ((term * fq) >> 32) / k;
      if (k % 2) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(64'd1 << 32)) acc = longint'(64'd1 << 32);
    a = acc;
    for (int k = 0; k < n; k++) a = (a * 64'(EXP_M1_Q32)) >> 32;
    a = (a + 64'd32768) >> 16;
    if (a > 64'd65536) a = 64'd65536;
    return a[16:0];
  endfunction

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // full forward pass; queues one expected output per network output
  task automatic predict_outputs();
    logic [16:0] phi [NUNIT];
    logic [63:0] sum, d, b, den;
    longint acc;
    rbfe_res_t r;
    for (int u = 0; u < NUNIT; u++) begin
      sum = '0;
      for (int i = 0; i < NIN; i++) begin
        d = mag(longint'(p_input[i]) - longint'(p_center[u*NIN+i]));
        b = mag(longint'(p_width[u*NIN+i]));
        den = b * b;
        if (den < 64'(DEN_FLOOR)) den = 64'(DEN_FLOOR);
        sum += ratio_q16(d * d, den);
        if (sum > 64'(SUM_CAP)) sum = 64'(SUM_CAP);
      end
      phi[u] = gauss_act(sum);
    end
    for (int k = 0; k < NOUT; k++) begin
      acc = longint'(p_bias[k]) * 65536;
      for (int u = 0; u < NUNIT; u++)
        acc += longint'(p_weight[u*NOUT+k]) * longint'({1'b0, phi[u]});
      r.output_index = k[0];
      if (acc <= 0) r.output_value = '0;
      else if (acc >= (longint'(1) << 32)) r.output_value = PHI_ONE;
      else r.output_value = 17'(acc >> 16);
      r.last = (k == NOUT - 1);
      expected_outputs = {expected_outputs, r};
    end
  endtask

  // update the predictor with one accepted request
  task automatic apply_request(rbfe_req_t q);
    int idx, unit, off;
    idx = int'(q.index);
    if (q.mode == MODE_LOAD) begin
      if (idx < NOUT) begin
        p_bias[idx] = q.value;
      end else if (idx < NWORDS) begin
        unit = (idx - NOUT) / UNIT_WORDS;
        off = (idx - NOUT) % UNIT_WORDS;
        if (off < 2 * NIN) begin
          if (off % 2) p_width[unit*NIN + off/2] = q.value;
          else p_center[unit*NIN + off/2] = q.value;
        end else begin
          p_weight[unit*NOUT + off - 2*NIN] = q.value;
        end
      end
    end else if (idx < NIN) begin
      p_input[idx] = q.value;
      if (idx == NIN - 1) predict_outputs();
    end
  endtask

  // send one request, with random idle cycles ahead of it
  task automatic send_request(logic m, logic [6:0] idx, logic [31:0] v);
    while (idle_enable && $urandom_range(99) < 23) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= '{mode: m, index: idx, value: v};
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    apply_request(req);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
  endtask

  // small Q16.16 value in +-lim (lim in 1/16 units)
  function automatic logic [31:0] small_q16(int lim);
    return 32'($signed($urandom_range(2 * lim * 4096)) - lim * 4096);
  endfunction

  function automatic logic [31:0] param_value(int off);
    if ($urandom_range(99) < 8) return $urandom;
    if (off < 2 * NIN && off % 2) begin
      if ($urandom_range(19) == 0) return '0;
      return $urandom_range(1) ? 32'($urandom_range(262144, 16384))
                               : -32'($urandom_range(262144, 16384));
    end
    return small_q16(32);
  endfunction

  // write every parameter word in file order
  task automatic load_all_params();
    send_request(MODE_LOAD, 7'd0, small_q16(8));
    send_request(MODE_LOAD, 7'd1, small_q16(8));
    for (int w = NOUT; w < NWORDS; w++)
      send_request(MODE_LOAD, 7'(w), param_value((w - NOUT) % UNIT_WORDS));
  endtask

  task automatic send_vector();
    logic [31:0] base;
    base = small_q16(32);
    for (int i = 0; i < NIN; i++)
      send_request(MODE_SAMPLE, 7'(i),
                   $urandom_range(99) < 10 ? $urandom : base + small_q16(16));
  endtask

  task automatic test_directed();
    load_all_params();
    // input at zero, then at the extremes of the value range
    for (int i = 0; i < NIN; i++) send_request(MODE_SAMPLE, 7'(i), 32'h0);
    for (int i = 0; i < NIN; i++) send_request(MODE_SAMPLE, 7'(i), 32'h8000_0000);
    for (int i = 0; i < NIN; i++) send_request(MODE_SAMPLE, 7'(i), 32'h7FFF_FFFF);
    // input exactly on the centers of unit 0, zero width: floor on denominator
    for (int i = 0; i < NIN; i++) begin
      send_request(MODE_LOAD, 7'(NOUT + 2*i + 1), 32'h0);
      send_request(MODE_SAMPLE, 7'(i), p_center[i]);
    end
    // bias clamps low and high; ignored loads and samples
    send_request(MODE_LOAD, 7'd0, 32'h8000_0000);
    send_request(MODE_LOAD, 7'd1, 32'h7FFF_FFFF);
    send_request(MODE_LOAD, 7'(NWORDS), 32'h1234_5678);
    send_request(MODE_LOAD, 7'd127, 32'hFFFF_FFFF);
    send_request(MODE_SAMPLE, 7'(NIN), 32'h0);
    send_request(MODE_SAMPLE, 7'd127, 32'h0);
    send_request(MODE_SAMPLE, 7'(NIN - 1), 32'h0001_0000);
  endtask

  task automatic test_random(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      idle_enable = !(sent > n_items / 3 && sent < n_items / 2);
      if (sent > n_items / 2 && sent < n_items / 2 + 12) wait_drained();
      case ($urandom_range(9))
        0: begin
          load_all_params();
          sent += NWORDS;
        end
        1: begin
          send_request(MODE_LOAD, 7'($urandom_range(127)), $urandom);
          send_request(MODE_SAMPLE, 7'($urandom_range(127)), $urandom);
          sent += 2;
        end
        default: begin
          send_vector();
          sent += NIN;
        end
      endcase
    end
    idle_enable = 1'b1;
  endtask

  // idle pattern on the result side
  always @(posedge clk)
    res_stall <= idle_enable && ($urandom_range(99) < 23);

  // result checker
  always @(posedge clk) begin
    rbfe_res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output %p", res);
      end else begin
        e = expected_outputs.pop_front();
        if (res.output_index !== e.output_index || res.output_value !== e.output_value ||
            res.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) $display("output mismatch: expected %p, got %p", e, res);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(370);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
